// File: rtl/tvp_pkg.sv
package tvp_pkg;

    // Default number of fraction bits of every speed, distance and time.
    localparam int TVP_FRAC_BITS_DEF = 16;

    // Default shape of the pipelined divider: 64-bit dividend, 32-bit divisor,
    // 32 quotient bits.
    localparam int DIV_NW_DEF = 64;
    localparam int DIV_DW_DEF = 32;
    localparam int DIV_QW_DEF = 32;

    // Default radicand width of the pipelined square root.
    localparam int SQRT_RW_DEF = 64;

    // One move segment as it enters the planner.
    typedef struct packed {
        logic signed [31:0] move_distance;
        logic signed [31:0] start_speed;
        logic signed [31:0] end_speed;
        logic signed [31:0] target_speed;
        logic signed [31:0] accel_rate;
    } t_seg_item;

    // One planned profile as it leaves the planner.
    typedef struct packed {
        logic [30:0]        ramp_up_length;
        logic [30:0]        steady_length;
        logic [30:0]        ramp_down_length;
        logic [30:0]        plateau_speed;
        logic signed [31:0] used_entry_speed;
        logic signed [31:0] used_exit_speed;
        logic signed [31:0] used_accel;
        logic [30:0]        move_time;
    } t_plan_item;

    // Saturate an unsigned 32-bit value to the 31-bit positive range.
    function automatic logic [30:0] sat31(input logic [31:0] v);
        sat31 = v[31] ? '1 : v[30:0];
    endfunction

endpackage

// File: rtl/tvp_if.sv
// Segment channel into the planner.
interface tvp_in_if;
    import tvp_pkg::*;
    logic      valid;
    logic      ready;
    t_seg_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// Profile channel out of the planner.
interface tvp_out_if;
    import tvp_pkg::*;
    logic       valid;
    logic       ready;
    t_plan_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: rtl/tvp_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage.
// The quotient saturates to all ones when it would not fit in QW bits.
module tvp_div_pipe #(
    parameter int NW = tvp_pkg::DIV_NW_DEF,
    parameter int DW = tvp_pkg::DIV_DW_DEF,
    parameter int QW = tvp_pkg::DIV_QW_DEF
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_xq  [0:QW];
    logic          r_ovf [0:QW];

    logic [DW-1:0] n_rem [0:QW-1];
    logic [QW-1:0] n_xq  [0:QW-1];
    logic [DW:0]   n_sh  [0:QW-1];
    logic          n_ge  [0:QW-1];
    logic [NW-1:0] w_hi;

    assign w_hi = i_num >> QW;

    // One shift-and-subtract step per stage; the dividend bits leave the top
    // of the shift word while quotient bits enter at the bottom.
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            n_sh[k]  = {r_rem[k], r_xq[k][QW-1]};
            n_ge[k]  = n_sh[k] >= {1'b0, r_den[k]};
            n_rem[k] = n_ge[k] ? DW'(n_sh[k] - {1'b0, r_den[k]}) : n_sh[k][DW-1:0];
            n_xq[k]  = {r_xq[k][QW-2:0], n_ge[k]};
        end
    end

    // Stage registers, advancing together on the pipeline enable.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(w_hi);
            r_den[0] <= i_den;
            r_xq[0]  <= i_num[QW-1:0];
            r_ovf[0] <= w_hi >= NW'(i_den);
            for (int k = 0; k < QW; k++) begin
                r_xq[k+1]  <= n_xq[k];
                r_ovf[k+1] <= r_ovf[k];
            end
            for (int k = 0; k < QW - 1; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_den[k+1] <= r_den[k];
            end
        end
    end

    assign o_quo = r_ovf[QW] ? '1 : r_xq[QW];

endmodule

// File: rtl/tvp_sqrt_pipe.sv
// Pipelined integer square root (floor): one root bit per stage.
module tvp_sqrt_pipe #(
    parameter int RW = tvp_pkg::SQRT_RW_DEF
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [RW-1:0]   i_rad,
    output logic [RW/2-1:0] o_root
);

    localparam int RH = RW / 2;

    logic [RW-1:0] r_x    [0:RH-1];
    logic [RH:0]   r_rem  [0:RH-1];
    logic [RH-1:0] r_root [0:RH];

    logic [RW-1:0] n_x    [0:RH-1];
    logic [RH:0]   n_rem  [0:RH-1];
    logic [RH-1:0] n_root [0:RH-1];
    logic [RH+2:0] n_sh   [0:RH-1];
    logic [RH+2:0] n_try  [0:RH-1];
    logic          n_ge   [0:RH-1];

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        for (int k = 0; k < RH; k++) begin
            n_sh[k]   = {r_rem[k], r_x[k][RW-1:RW-2]};
            n_try[k]  = {1'b0, r_root[k], 2'b01};
            n_ge[k]   = n_sh[k] >= n_try[k];
            n_rem[k]  = n_ge[k] ? (RH+1)'(n_sh[k] - n_try[k]) : (RH+1)'(n_sh[k]);
            n_root[k] = {r_root[k][RH-2:0], n_ge[k]};
            n_x[k]    = {r_x[k][RW-3:0], 2'b00};
        end
    end

    // Stage registers, advancing together on the pipeline enable.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int k = 0; k < RH; k++) begin
                r_root[k+1] <= n_root[k];
            end
            for (int k = 0; k < RH - 1; k++) begin
                r_x[k+1]   <= n_x[k];
                r_rem[k+1] <= n_rem[k];
            end
        end
    end

    assign o_root = r_root[RH];

endmodule

// File: rtl/trapezoid_velocity_planner_top.sv
// Trapezoidal velocity planner for one move segment at a time.
// A segment (distance, entry, exit and cruise speed, acceleration, all
// signed fixed point with FRAC_BITS fraction bits) enters on i_seg; the
// planned profile leaves on o_plan. Both channels move one item at a
// rising edge where valid and ready are high.
// The block is one deep pipeline: a new segment may enter every cycle
// unless a finished result is held back; segments never interact.
// Most of the depth lies in three pipelined units in a row: the ramp dividers
// together with the peak-speed square root (33 stages), the triangle
// ramp dividers (33 stages) and the time dividers (33 + FRAC_BITS stages).
// When the receiver holds o_plan.ready low while a result waits, the whole
// pipeline freezes and i_seg.ready falls; nothing is lost or repeated.
// Synchronous reset empties the pipeline; only the valid bits are cleared,
// and i_seg.ready is high again from the first cycle after reset.
module trapezoid_velocity_planner_top #(
    parameter int FRAC_BITS = tvp_pkg::TVP_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tvp_in_if.sink     i_seg,
    tvp_out_if.source  o_plan
);

    import tvp_pkg::*;

    localparam int DQ_W = 32;
    localparam int LA   = DQ_W + 1;
    localparam int LB   = DQ_W + 1;
    localparam int TQ_W = 32 + FRAC_BITS;
    localparam int TN_W = TQ_W + 1;
    localparam int LC   = TQ_W + 1;
    localparam int TS_W = TQ_W + 3;
    localparam int TOT  = 9 + LA + LB + LC;

    // Sideband of a segment up to the choice between trapezoid and triangle.
    typedef struct packed {
        logic        degen;
        logic [31:0] es;
        logic [31:0] xs;
        logic [31:0] acc;
        logic [30:0] ud;
        logic [30:0] ve;
        logic [30:0] vx;
        logic [30:0] vc;
        logic [61:0] ve2;
        logic [61:0] vx2;
        logic [31:0] twoa;
        logic [31:0] up;
        logic [31:0] dn;
        logic [31:0] pk;
        logic        is_tri;
    } t_side;

    // Sideband of a segment once its profile shape is fixed.
    typedef struct packed {
        logic        degen;
        logic [31:0] es;
        logic [31:0] xs;
        logic [31:0] acc;
        logic [30:0] ve;
        logic [30:0] vx;
        logic [31:0] vc;
        logic [31:0] up;
        logic [31:0] dn;
        logic [30:0] cr;
        logic        neg1;
        logic        neg2;
        logic        nz;
    } t_fin;

    logic           w_en;
    logic [TOT-1:0] r_vld;

    t_side          n1_side, r1_side, n2_side, r2_side, r3_side, n4_side, r4_side, r5_side;
    logic [61:0]    r2_vc2, r2_uaud;
    logic [61:0]    r3_nu, r3_nd;
    logic [62:0]    r3_rad;
    logic [63:0]    n3_sum;
    logic [63:0]    r4_pk2;
    logic [63:0]    r5_tnu, r5_tnd;
    t_side          r_dla [0:LA-1];
    t_side          r_dlb [0:LB-1];
    t_fin           r_dlc [0:LC-1];
    t_fin           n6_fin, r6_fin, n7_fin, r7_fin, r8_fin;
    logic [TN_W-1:0] r7_n1, r7_n2, r7_n3;
    logic [32:0]    n7_d1, n7_d2, n7_m1, n7_m2;
    logic [32:0]    n6_sum;
    logic [TS_W-1:0] n8_t1, n8_t2, n8_t3, r8_t;
    t_plan_item     n_out, r_out;

    logic [31:0]    w_qa_up, w_qa_dn, w_pk, w_qb_up, w_qb_dn;
    logic [TQ_W-1:0] w_q1, w_q2, w_q3;
    logic [30:0]    w_c0, w_m0;

    // The whole pipeline moves unless a finished result is held back.
    assign w_en        = !r_vld[TOT-1] || o_plan.ready;
    assign i_seg.ready = w_en;
    assign o_plan.valid = r_vld[TOT-1];
    assign o_plan.item  = r_out;

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT-2:0], i_seg.valid};
        end
    end

    // Stage 1: clamp the speeds and flag degenerate segments.
    always_comb begin
        n1_side       = '0;
        n1_side.es    = i_seg.item.start_speed;
        n1_side.xs    = i_seg.item.end_speed;
        n1_side.acc   = i_seg.item.accel_rate;
        n1_side.degen = i_seg.item.move_distance[31] || (i_seg.item.move_distance == '0) ||
                        i_seg.item.accel_rate[31] || (i_seg.item.accel_rate == '0);
        n1_side.ud    = i_seg.item.move_distance[30:0];
        n1_side.ve    = i_seg.item.start_speed[31] ? '0 : i_seg.item.start_speed[30:0];
        n1_side.vx    = i_seg.item.end_speed[31] ? '0 : i_seg.item.end_speed[30:0];
        w_c0          = i_seg.item.target_speed[31] ? '0 : i_seg.item.target_speed[30:0];
        w_m0          = (w_c0 < n1_side.ve) ? n1_side.ve : w_c0;
        n1_side.vc    = (w_m0 < n1_side.vx) ? n1_side.vx : w_m0;
    end

    // Stage 2: squares of the clamped speeds and twice the acceleration.
    always_comb begin
        n2_side      = r1_side;
        n2_side.ve2  = 62'(r1_side.ve) * 62'(r1_side.ve);
        n2_side.vx2  = 62'(r1_side.vx) * 62'(r1_side.vx);
        n2_side.twoa = {r1_side.acc[30:0], 1'b0};
    end

    // Stage 4: take the ramp lengths and the peak speed, flag a triangle, square the peak.
    always_comb begin
        n4_side        = r_dla[LA-1];
        n4_side.up     = w_qa_up;
        n4_side.dn     = w_qa_dn;
        n4_side.pk     = w_pk;
        n4_side.is_tri = ({1'b0, w_qa_up} + {1'b0, w_qa_dn}) > {2'b0, r_dla[LA-1].ud};
    end

    // Front stages: clamp, squares, ramp numerators, the radicand and the triangle ramp numerators.
    assign n3_sum = 64'({r2_uaud, 1'b0}) + 64'(r2_side.ve2) + 64'(r2_side.vx2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_side      <= n1_side;
            r2_side      <= n2_side;
            r2_vc2       <= 62'(r1_side.vc) * 62'(r1_side.vc);
            r2_uaud      <= 62'(r1_side.ud) * 62'(r1_side.acc[30:0]);
            r3_side      <= r2_side;
            r3_nu        <= r2_vc2 - r2_side.ve2;
            r3_nd        <= r2_vc2 - r2_side.vx2;
            r3_rad       <= n3_sum[63:1];
            r4_side      <= n4_side;
            r4_pk2       <= 64'(w_pk) * 64'(w_pk);
            r5_side      <= r4_side;
            r5_tnu       <= (r4_pk2 > 64'(r4_side.ve2)) ? r4_pk2 - 64'(r4_side.ve2) : '0;
            r5_tnd       <= (r4_pk2 > 64'(r4_side.vx2)) ? r4_pk2 - 64'(r4_side.vx2) : '0;
        end
    end

    // Ramp lengths of the trapezoid and the triangle peak speed.
    tvp_div_pipe #(.NW(64), .DW(32), .QW(DQ_W)) u_div_up_a (
        .i_clk (i_clk), .i_en (w_en), .i_num ({2'b00, r3_nu}),
        .i_den (r3_side.twoa), .o_quo (w_qa_up)
    );
    tvp_div_pipe #(.NW(64), .DW(32), .QW(DQ_W)) u_div_dn_a (
        .i_clk (i_clk), .i_en (w_en), .i_num ({2'b00, r3_nd}),
        .i_den (r3_side.twoa), .o_quo (w_qa_dn)
    );
    tvp_sqrt_pipe #(.RW(64)) u_sqrt_pk (
        .i_clk (i_clk), .i_en (w_en), .i_rad ({1'b0, r3_rad}), .o_root (w_pk)
    );

    // Ramp lengths of the triangle profile.
    tvp_div_pipe #(.NW(64), .DW(32), .QW(DQ_W)) u_div_up_b (
        .i_clk (i_clk), .i_en (w_en), .i_num (r5_tnu),
        .i_den (r5_side.twoa), .o_quo (w_qb_up)
    );
    tvp_div_pipe #(.NW(64), .DW(32), .QW(DQ_W)) u_div_dn_b (
        .i_clk (i_clk), .i_en (w_en), .i_num (r5_tnd),
        .i_den (r5_side.twoa), .o_quo (w_qb_dn)
    );

    // Sideband delay lines matched to the unit latencies.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dla[0] <= r3_side;
            r_dlb[0] <= r5_side;
            r_dlc[0] <= r7_fin;
            for (int k = 1; k < LA; k++) begin
                r_dla[k] <= r_dla[k-1];
            end
            for (int k = 1; k < LB; k++) begin
                r_dlb[k] <= r_dlb[k-1];
            end
            for (int k = 1; k < LC; k++) begin
                r_dlc[k] <= r_dlc[k-1];
            end
        end
    end

    // Stage 6: pick trapezoid or triangle and work out the cruise length.
    always_comb begin
        n6_fin       = '0;
        n6_fin.degen = r_dlb[LB-1].degen;
        n6_fin.es    = r_dlb[LB-1].es;
        n6_fin.xs    = r_dlb[LB-1].xs;
        n6_fin.acc   = r_dlb[LB-1].acc;
        n6_fin.ve    = r_dlb[LB-1].ve;
        n6_fin.vx    = r_dlb[LB-1].vx;
        if (r_dlb[LB-1].is_tri) begin
            n6_fin.vc = r_dlb[LB-1].pk;
            n6_fin.up = w_qb_up;
            n6_fin.dn = w_qb_dn;
        end else begin
            n6_fin.vc = {1'b0, r_dlb[LB-1].vc};
            n6_fin.up = r_dlb[LB-1].up;
            n6_fin.dn = r_dlb[LB-1].dn;
        end
        n6_sum    = {1'b0, n6_fin.up} + {1'b0, n6_fin.dn};
        n6_fin.cr = (n6_sum >= {2'b0, r_dlb[LB-1].ud}) ? '0 :
                    r_dlb[LB-1].ud - n6_sum[30:0];
    end

    // Stage 7: signed speed differences for the ramp times.
    always_comb begin
        n7_fin      = r6_fin;
        n7_d1       = {1'b0, r6_fin.vc} - {2'b0, r6_fin.ve};
        n7_d2       = {1'b0, r6_fin.vc} - {2'b0, r6_fin.vx};
        n7_fin.neg1 = n7_d1[32];
        n7_fin.neg2 = n7_d2[32];
        n7_fin.nz   = r6_fin.vc != '0;
        n7_m1       = n7_d1[32] ? 33'(0) - n7_d1 : n7_d1;
        n7_m2       = n7_d2[32] ? 33'(0) - n7_d2 : n7_d2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_fin <= n6_fin;
            r7_fin <= n7_fin;
            r7_n1  <= {1'b0, n7_m1[31:0], {FRAC_BITS{1'b0}}};
            r7_n2  <= {1'b0, n7_m2[31:0], {FRAC_BITS{1'b0}}};
            r7_n3  <= {2'b00, r6_fin.cr, {FRAC_BITS{1'b0}}};
        end
    end

    // Phase times: ramp up, ramp down and cruise.
    tvp_div_pipe #(.NW(TN_W), .DW(32), .QW(TQ_W)) u_div_t1 (
        .i_clk (i_clk), .i_en (w_en), .i_num (r7_n1),
        .i_den ({1'b0, r7_fin.acc[30:0]}), .o_quo (w_q1)
    );
    tvp_div_pipe #(.NW(TN_W), .DW(32), .QW(TQ_W)) u_div_t2 (
        .i_clk (i_clk), .i_en (w_en), .i_num (r7_n2),
        .i_den ({1'b0, r7_fin.acc[30:0]}), .o_quo (w_q2)
    );
    tvp_div_pipe #(.NW(TN_W), .DW(32), .QW(TQ_W)) u_div_t3 (
        .i_clk (i_clk), .i_en (w_en), .i_num (r7_n3),
        .i_den (r7_fin.vc), .o_quo (w_q3)
    );

    // Stage 8: signed sum of the phase times; a ramp time whose speed
    // difference was negative counts against the total.
    always_comb begin
        n8_t1 = {3'b000, w_q1};
        n8_t2 = {3'b000, w_q2};
        n8_t3 = r_dlc[LC-1].nz ? {3'b000, w_q3} : '0;
        if (r_dlc[LC-1].neg1) begin
            n8_t1 = TS_W'(0) - n8_t1;
        end
        if (r_dlc[LC-1].neg2) begin
            n8_t2 = TS_W'(0) - n8_t2;
        end
    end

    // Output register: saturation and the degenerate case.
    always_comb begin
        n_out.used_accel = r8_fin.acc;
        if (r8_fin.degen) begin
            n_out.ramp_up_length   = '0;
            n_out.steady_length    = '0;
            n_out.ramp_down_length = '0;
            n_out.plateau_speed    = '0;
            n_out.used_entry_speed = r8_fin.es;
            n_out.used_exit_speed  = r8_fin.xs;
            n_out.move_time        = '0;
        end else begin
            n_out.ramp_up_length   = sat31(r8_fin.up);
            n_out.steady_length    = r8_fin.cr;
            n_out.ramp_down_length = sat31(r8_fin.dn);
            n_out.plateau_speed    = sat31(r8_fin.vc);
            n_out.used_entry_speed = {1'b0, r8_fin.ve};
            n_out.used_exit_speed  = {1'b0, r8_fin.vx};
            if (r8_t[TS_W-1]) begin
                n_out.move_time = '0;
            end else if (r8_t[TS_W-2:31] != '0) begin
                n_out.move_time = '1;
            end else begin
                n_out.move_time = r8_t[30:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_fin <= r_dlc[LC-1];
            r8_t   <= n8_t1 + n8_t2 + n8_t3;
            r_out  <= n_out;
        end
    end

endmodule
